>>> hw/rtl/dnd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnd_pkg - DNS name decompressor shared definitions
// Sizes, status codes, item types and walker states used across the block.
// ----------------------------------------------------------------------------
package dnd_pkg;

	// packet buffer
	localparam int PACKET_BYTES = 2048;
	localparam int ADDR_W       = $clog2(PACKET_BYTES);
	localparam int LEN_W        = $clog2(PACKET_BYTES + 1);

	// name walk limits and field widths
	localparam int MAX_LABELS = 63;
	localparam int POS_W      = 14;
	localparam int NEXT_W     = 15;
	localparam int LLEN_W     = 6;
	localparam int JUMP_W     = 6;
	localparam int STAT_W     = 3;

	localparam logic [LLEN_W-1:0] LABEL_CAP     = LLEN_W'(MAX_LABELS);
	localparam logic [JUMP_W-1:0] MAX_JUMPS_RST = JUMP_W'(16);

	// label byte: top two bits give the type, low six the length or pointer
	localparam logic [7:0] LABEL_TYPE_MASK = 8'hc0;
	localparam logic [7:0] LABEL_LEN_MASK  = 8'h3f;

	// queues between the parts
	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);

	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_DECODE = 1'b1
	} cmd_kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_PAST_END = 3'd1,
		ST_BAD_PTR  = 3'd2,
		ST_JUMPS    = 3'd3,
		ST_RESERVED = 3'd4,
		ST_OVERRUN  = 3'd5,
		ST_LABELS   = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		WS_IDLE,
		WS_CHECK,
		WS_LEN,
		WS_PTR,
		WS_FINAL
	} walk_state_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [7:0]       data_byte;
		logic             packet_start;
		logic [POS_W-1:0] start_position;
	} cmd_t;

	// command link from front to back
	typedef struct packed {
		logic valid;
		cmd_t item;
	} cmd_link_t;

	typedef struct packed {
		logic              is_final;
		logic [POS_W-1:0]  label_offset;
		logic [LLEN_W-1:0] label_length;
		status_t           status;
		logic [NEXT_W-1:0] next_position;
		logic              last_result;
	} res_t;

endpackage
`default_nettype wire

>>> hw/rtl/dnd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnd_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module dnd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

>>> hw/rtl/dnd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnd_front - input side of the decompressor
// Accept items, tag them as load or decode and queue them for the walker.
// ----------------------------------------------------------------------------
module dnd_front
	import dnd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output      logic             full,
	input  wire logic             command,
	input  wire logic [7:0]       data_byte,
	input  wire logic             packet_start,
	input  wire logic [POS_W-1:0] start_position,
	output      cmd_link_t        cmd_link,
	input  wire logic             cmd_take
);

	cmd_t                 slot_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_PTR_W:0]   count_q;
	logic                 do_push;
	logic                 do_pop;
	cmd_t                 item_in;

	assign full    = (count_q == (CMD_PTR_W+1)'(CMD_DEPTH));
	assign do_push = push && !full;
	assign do_pop  = cmd_take && (count_q != '0);

	always_comb begin
		item_in.kind           = command ? CMD_DECODE : CMD_LOAD;
		item_in.data_byte      = data_byte;
		item_in.packet_start   = packet_start;
		item_in.start_position = start_position;
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign cmd_link.valid = (count_q != '0);
	assign cmd_link.item  = slot_q[rd_ptr_q];

endmodule
`default_nettype wire

>>> hw/rtl/dnd_walker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnd_walker - back side of the decompressor
// Store packet bytes and walk names through labels and pointers.
// ----------------------------------------------------------------------------
module dnd_walker
	import dnd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_link_t         cmd_link,
	output      logic              cmd_take,
	input  wire logic [JUMP_W-1:0] max_jumps,
	output      logic              res_push,
	output      res_t              res_item,
	input  wire logic              res_full
);

	walk_state_t        state_q, state_d;
	logic [LEN_W-1:0]   length_q;
	logic [POS_W-1:0]   p_q;
	logic [NEXT_W-1:0]  next_q;
	logic [JUMP_W-1:0]  jumps_q;
	logic [LLEN_W-1:0]  labels_q;
	logic               jumped_q;
	logic [LLEN_W-1:0]  hi_q;
	status_t            status_q;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [7:0]         rd_byte;

	logic               is_load;
	logic               is_decode;
	logic [LEN_W-1:0]   eff_len;
	logic               room;
	logic [NEXT_W-1:0]  size;
	logic [NEXT_W-1:0]  p_ext;
	logic [NEXT_W-1:0]  p_plus1;
	logic [NEXT_W-1:0]  p_plus2;
	logic [LLEN_W-1:0]  len6;
	logic [NEXT_W-1:0]  label_end;
	logic [POS_W-1:0]   ptr_target;
	logic               p_past;
	logic               is_end;
	logic               is_ptr;
	logic               is_rsv;
	logic               ptr_past;
	logic               jump_over;
	logic               overrun;
	logic               at_cap;
	logic               ptr_bad;
	logic               label_ok;

	dnd_ram #(
		.WIDTH(8),
		.DEPTH(PACKET_BYTES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(cmd_link.item.data_byte),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rd_byte)
	);

	// decisions
	assign is_load   = cmd_link.valid && (cmd_link.item.kind == CMD_LOAD);
	assign is_decode = cmd_link.valid && (cmd_link.item.kind == CMD_DECODE);
	assign eff_len   = cmd_link.item.packet_start ? '0 : length_q;
	assign room      = (eff_len < LEN_W'(PACKET_BYTES));

	assign size       = NEXT_W'(length_q);
	assign p_ext      = NEXT_W'(p_q);
	assign p_plus1    = p_ext + NEXT_W'(1);
	assign p_plus2    = p_ext + NEXT_W'(2);
	assign len6       = rd_byte[LLEN_W-1:0] & LABEL_LEN_MASK[LLEN_W-1:0];
	assign label_end  = p_plus1 + NEXT_W'(len6);
	assign ptr_target = {hi_q, rd_byte};

	assign p_past    = (p_ext >= size);
	assign is_end    = (rd_byte == 8'h00);
	assign is_ptr    = ((rd_byte & LABEL_TYPE_MASK) == LABEL_TYPE_MASK);
	assign is_rsv    = ((rd_byte & LABEL_TYPE_MASK) != 8'h00) && !is_ptr;
	assign ptr_past  = (p_plus1 >= size);
	assign jump_over = ((JUMP_W+1)'(jumps_q) + (JUMP_W+1)'(1)) > (JUMP_W+1)'(max_jumps);
	assign overrun   = (label_end > size);
	assign at_cap    = (labels_q >= LABEL_CAP);
	assign ptr_bad   = (NEXT_W'(ptr_target) >= size);
	assign label_ok  = !is_end && !is_ptr && !is_rsv && !overrun && !at_cap;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			WS_IDLE: begin
				if (is_decode) begin
					state_d = WS_CHECK;
				end
			end
			WS_CHECK: begin
				state_d = p_past ? WS_FINAL : WS_LEN;
			end
			WS_LEN: begin
				if (is_ptr && !ptr_past && !jump_over) begin
					state_d = WS_PTR;
				end else if (label_ok) begin
					if (!res_full) begin
						state_d = WS_CHECK;
					end
				end else begin
					state_d = WS_FINAL;
				end
			end
			WS_PTR: begin
				state_d = ptr_bad ? WS_FINAL : WS_CHECK;
			end
			WS_FINAL: begin
				if (!res_full) begin
					state_d = WS_IDLE;
				end
			end
			default: state_d = WS_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = eff_len[ADDR_W-1:0];
		ram_re    = 1'b0;
		ram_raddr = p_q[ADDR_W-1:0];
		cmd_take  = 1'b0;
		res_push  = 1'b0;
		res_item  = '0;
		case (state_q)
			WS_IDLE: begin
				if (is_load) begin
					ram_we   = room;
					cmd_take = 1'b1;
				end
			end
			WS_CHECK: begin
				ram_re = !p_past;
			end
			WS_LEN: begin
				if (is_ptr && !ptr_past && !jump_over) begin
					ram_re    = 1'b1;
					ram_raddr = p_plus1[ADDR_W-1:0];
				end else if (label_ok && !res_full) begin
					res_push              = 1'b1;
					res_item.label_offset = p_plus1[POS_W-1:0];
					res_item.label_length = len6;
					res_item.status       = ST_OK;
				end
			end
			WS_FINAL: begin
				if (!res_full) begin
					res_push               = 1'b1;
					cmd_take               = 1'b1;
					res_item.is_final      = 1'b1;
					res_item.status        = status_q;
					res_item.next_position = (status_q == ST_OK) ? next_q : '0;
					res_item.last_result   = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= WS_IDLE;
			length_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == WS_IDLE && is_load) begin
				length_q <= room ? eff_len + 1'b1 : eff_len;
			end
		end
	end

	// walk registers
	always_ff @(posedge clk) begin
		case (state_q)
			WS_IDLE: begin
				p_q      <= cmd_link.item.start_position;
				next_q   <= '0;
				jumps_q  <= '0;
				labels_q <= '0;
				jumped_q <= 1'b0;
				status_q <= ST_OK;
			end
			WS_CHECK: begin
				if (p_past) begin
					status_q <= ST_PAST_END;
				end
			end
			WS_LEN: begin
				hi_q <= len6;
				if (is_end) begin
					status_q <= ST_OK;
					if (!jumped_q) begin
						next_q <= p_plus1;
					end
				end else if (is_ptr) begin
					if (ptr_past) begin
						status_q <= ST_PAST_END;
					end else if (jump_over) begin
						status_q <= ST_JUMPS;
					end
				end else if (is_rsv) begin
					status_q <= ST_RESERVED;
				end else if (overrun) begin
					status_q <= ST_OVERRUN;
				end else if (at_cap) begin
					status_q <= ST_LABELS;
				end else if (!res_full) begin
					p_q      <= label_end[POS_W-1:0];
					labels_q <= labels_q + 1'b1;
				end
			end
			WS_PTR: begin
				if (ptr_bad) begin
					status_q <= ST_BAD_PTR;
				end else begin
					if (!jumped_q) begin
						next_q <= p_plus2;
					end
					p_q      <= ptr_target;
					jumped_q <= 1'b1;
					jumps_q  <= jumps_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

>>> hw/rtl/dnd_res_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnd_res_queue - result queue
// Hold finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module dnd_res_queue
	import dnd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic res_push,
	input  wire res_t res_in,
	output      logic res_full,
	input  wire logic pop,
	output      logic empty,
	output      res_t res_out
);

	res_t                 slot_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q;
	logic [RES_PTR_W-1:0] rd_ptr_q;
	logic [RES_PTR_W:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign res_full = (count_q == (RES_PTR_W+1)'(RES_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = res_push && !res_full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign res_out = slot_q[rd_ptr_q];

endmodule
`default_nettype wire

>>> hw/rtl/dns_name_decompressor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dns_name_decompressor - DNS name decompressor top level
// Packet buffer loader and compressed-name walker behind two queues.
// ----------------------------------------------------------------------------
// Items enter through a four-deep command queue and are carried out in order.
// A load item (command 0) stores one byte in the 2048-byte packet buffer;
// packet_start restarts the packet at offset zero, and bytes past capacity
// are dropped. A decode item (command 1) walks the name at start_position
// and yields one label result per label followed by one final result with
// the status, next_position and last_result set. Decode time is set by the
// single read port of the packet buffer: each label is read and then judged,
// and each compression pointer followed adds a read of its second byte.
// Results wait in a four-deep result queue, so the walk runs on while the
// consumer holds pop low until that queue fills.
// max_jumps resets to 16; the user must write it only while no item is in
// flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module dns_name_decompressor
	import dnd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// input queue side
	input  wire logic              push,
	output      logic              full,
	input  wire logic              command,
	input  wire logic [7:0]        data_byte,
	input  wire logic              packet_start,
	input  wire logic [POS_W-1:0]  start_position,
	// configuration
	input  wire logic              max_jumps_we,
	input  wire logic [JUMP_W-1:0] max_jumps_data,
	// result queue side
	output      logic              empty,
	input  wire logic              pop,
	output      logic              is_final,
	output      logic [POS_W-1:0]  label_offset,
	output      logic [LLEN_W-1:0] label_length,
	output      logic [STAT_W-1:0] status,
	output      logic [NEXT_W-1:0] next_position,
	output      logic              last_result
);

	logic [JUMP_W-1:0] max_jumps_q;
	cmd_link_t         cmd_link;
	logic              cmd_take;
	logic              res_push;
	res_t              res_item;
	logic              res_full;
	res_t              res_out;

	// hold the jump limit; the user must write it only while idle (not enforced)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_jumps_q <= MAX_JUMPS_RST;
		end else if (max_jumps_we) begin
			max_jumps_q <= max_jumps_data;
		end
	end

	// front: accept and tag items
	dnd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.command       (command),
		.data_byte     (data_byte),
		.packet_start  (packet_start),
		.start_position(start_position),
		.cmd_link      (cmd_link),
		.cmd_take      (cmd_take)
	);

	// back: store bytes and walk names
	dnd_walker u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_link (cmd_link),
		.cmd_take (cmd_take),
		.max_jumps(max_jumps_q),
		.res_push (res_push),
		.res_item (res_item),
		.res_full (res_full)
	);

	// results wait here for the consumer
	dnd_res_queue u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.res_push(res_push),
		.res_in  (res_item),
		.res_full(res_full),
		.pop     (pop),
		.empty   (empty),
		.res_out (res_out)
	);

	assign is_final      = res_out.is_final;
	assign label_offset  = res_out.label_offset;
	assign label_length  = res_out.label_length;
	assign status        = res_out.status;
	assign next_position = res_out.next_position;
	assign last_result   = res_out.last_result;

endmodule
`default_nettype wire

>>> hw/rtl/dnd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnd_checker - port-level assertions for the decompressor
// Check reset state, the shape of label and final results and status codes.
// ----------------------------------------------------------------------------
module dnd_checker
	import dnd_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              full,
	input wire logic              empty,
	input wire logic              is_final,
	input wire logic [POS_W-1:0]  label_offset,
	input wire logic [LLEN_W-1:0] label_length,
	input wire logic [STAT_W-1:0] status,
	input wire logic [NEXT_W-1:0] next_position,
	input wire logic              last_result
);

	a_reset_queues: assert property (@(posedge clk)
		!arst_n |-> (empty && !full))
		else $error("queues not cleared in reset");

	a_label_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !is_final) |-> (!last_result && status == ST_OK && next_position == '0))
		else $error("label item carries closing fields");

	a_final_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && is_final) |-> (last_result && label_offset == '0 && label_length == '0))
		else $error("final item malformed");

	a_fail_next: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && is_final && status != ST_OK) |-> (next_position == '0))
		else $error("failed decode reports a next position");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status <= ST_LABELS))
		else $error("undefined status code");

endmodule

bind dns_name_decompressor dnd_checker u_dnd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.full         (full),
	.empty        (empty),
	.is_final     (is_final),
	.label_offset (label_offset),
	.label_length (label_length),
	.status       (status),
	.next_position(next_position),
	.last_result  (last_result)
);
`default_nettype wire

>>> bench/tb_dns_name_decompressor.sv
// ----------------------------------------------------------------------------
// tb_dns_name_decompressor - self-checking bench for the DNS name decompressor
// Loads packets byte by byte, decodes names at chosen offsets and compares
// every label and final result against a local walk of the same packet.
// ----------------------------------------------------------------------------
module tb_dns_name_decompressor;
	import dnd_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 3_000_000;
	localparam int unsigned DRAIN_CYCLES = 24;
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned IDLE_MAX     = 18;
	localparam int unsigned RANDOM_ITEMS = 470;
	localparam int unsigned RANDOM_PHASES = 5;

	typedef logic [7:0] byte_q_t[$];

	logic              clk            = 1'b0;
	logic              arst_n         = 1'b1;
	logic              push           = 1'b0;
	logic              command        = 1'b0;
	logic [7:0]        data_byte      = '0;
	logic              packet_start   = 1'b0;
	logic [POS_W-1:0]  start_position = '0;
	logic              max_jumps_we   = 1'b0;
	logic [JUMP_W-1:0] max_jumps_data = '0;
	logic              pop            = 1'b0;
	logic              full;
	logic              empty;
	logic              is_final;
	logic [POS_W-1:0]  label_offset;
	logic [LLEN_W-1:0] label_length;
	logic [STAT_W-1:0] status;
	logic [NEXT_W-1:0] next_position;
	logic              last_result;

	dns_name_decompressor dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.command        (command),
		.data_byte      (data_byte),
		.packet_start   (packet_start),
		.start_position (start_position),
		.max_jumps_we   (max_jumps_we),
		.max_jumps_data (max_jumps_data),
		.empty          (empty),
		.pop            (pop),
		.is_final       (is_final),
		.label_offset   (label_offset),
		.label_length   (label_length),
		.status         (status),
		.next_position  (next_position),
		.last_result    (last_result)
	);

	always #1 clk = ~clk;

	// Local copy of the packet buffer and the jump limit, kept in step with
	// the items the block accepts.
	logic [7:0]        packet_copy [PACKET_BYTES];
	int unsigned       packet_fill = 0;
	logic [JUMP_W-1:0] jump_limit  = MAX_JUMPS_RST;

	cmd_t        pending_items[$];   // items waiting for the driver
	res_t        due_results[$];     // results the block still owes, oldest first
	cmd_t        offered_item;
	int unsigned queued_count  = 0;
	int unsigned fail_count    = 0;
	int unsigned cycle_count   = 0;
	int unsigned send_idle_max = IDLE_MAX;
	int unsigned recv_idle_max = IDLE_MAX;
	int unsigned send_wait     = 0;
	int unsigned recv_wait     = 0;
	int unsigned hold_requests = 0;
	int unsigned holds_served  = 0;

	function automatic int unsigned draw_wait(input int unsigned top);
		return (top == 0) ? 0 : $urandom_range(0, top);
	endfunction

	// Walk the name at 'start' through the local buffer and append the label
	// results and the closing status to the expected results.
	function automatic void walk_name(input logic [POS_W-1:0] start);
		int unsigned p;
		int unsigned nxt;
		int unsigned jumps;
		int unsigned labels;
		int unsigned ptr;
		logic [7:0]  lbyte;
		bit          jumped;
		bit          done;
		status_t     st;
		res_t        r;
		p      = start;
		nxt    = 0;
		jumps  = 0;
		labels = 0;
		jumped = 1'b0;
		done   = 1'b0;
		st     = ST_OK;
		while (!done) begin
			if (p >= packet_fill) begin
				st   = ST_PAST_END;
				done = 1'b1;
			end else begin
				lbyte = packet_copy[p];
				if (lbyte == 8'h00) begin
					// root label: the name ends here
					p++;
					if (!jumped)
						nxt = p;
					st   = ST_OK;
					done = 1'b1;
				end else if ((lbyte & LABEL_TYPE_MASK) == LABEL_TYPE_MASK) begin
					if (p + 1 >= packet_fill) begin
						st   = ST_PAST_END;
						done = 1'b1;
					end else begin
						jumps++;
						ptr = {lbyte & LABEL_LEN_MASK, packet_copy[p + 1]};
						if (jumps > jump_limit) begin
							st   = ST_JUMPS;
							done = 1'b1;
						end else if (ptr >= packet_fill) begin
							st   = ST_BAD_PTR;
							done = 1'b1;
						end else begin
							// only the first pointer fixes where the name ends
							if (!jumped)
								nxt = p + 2;
							p      = ptr;
							jumped = 1'b1;
						end
					end
				end else if ((lbyte & LABEL_TYPE_MASK) != 8'h00) begin
					st   = ST_RESERVED;
					done = 1'b1;
				end else if (p + 1 + lbyte > packet_fill) begin
					st   = ST_OVERRUN;
					done = 1'b1;
				end else if (labels >= MAX_LABELS) begin
					st   = ST_LABELS;
					done = 1'b1;
				end else begin
					r              = '0;
					r.status       = ST_OK;
					r.label_offset = POS_W'(p + 1);
					r.label_length = LLEN_W'(lbyte);
					due_results.push_back(r);
					labels++;
					p += 1 + lbyte;
				end
			end
		end
		r               = '0;
		r.is_final      = 1'b1;
		r.status        = st;
		r.next_position = (st == ST_OK) ? NEXT_W'(nxt) : '0;
		r.last_result   = 1'b1;
		due_results.push_back(r);
	endfunction

	// Update the local buffer for a load, or predict the results of a decode.
	function automatic void apply_item(input cmd_t c);
		if (c.kind == CMD_LOAD) begin
			if (c.packet_start)
				packet_fill = 0;
			// drop bytes past capacity, keep the length
			if (packet_fill < PACKET_BYTES) begin
				packet_copy[packet_fill] = c.data_byte;
				packet_fill++;
			end
		end else begin
			walk_name(c.start_position);
		end
	endfunction

	function automatic void queue_packet(input byte_q_t bytes, input bit fresh);
		cmd_t c;
		foreach (bytes[i]) begin
			c.kind           = CMD_LOAD;
			c.data_byte      = bytes[i];
			c.packet_start   = fresh && (i == 0);
			c.start_position = POS_W'($urandom);   // ignored by a load
			pending_items.push_back(c);
			queued_count++;
		end
	endfunction

	function automatic void queue_decode(input logic [POS_W-1:0] pos);
		cmd_t c;
		c.kind           = CMD_DECODE;
		c.data_byte      = 8'($urandom);          // ignored by a decode
		c.packet_start   = 1'($urandom);
		c.start_position = pos;
		pending_items.push_back(c);
		queued_count++;
	endfunction

	// Build one packet and a few decodes. Most packets are well-formed names,
	// some chaining compression pointers to earlier names; the rest are noise,
	// corrupted bytes or an append without a packet start.
	function automatic void queue_random_packet();
		byte_q_t     pkt;
		int unsigned targets[$];
		int unsigned new_targets[$];
		int unsigned starts[$];
		int unsigned len;
		int unsigned t;
		int unsigned pick;
		if ($urandom_range(0, 9) < 2) begin
			repeat ($urandom_range(1, 24))
				pkt.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(0, 3))
				pkt.push_back(8'($urandom));
			repeat ($urandom_range(1, 4)) begin
				starts.push_back(pkt.size());
				new_targets = '{};
				new_targets.push_back(pkt.size());
				repeat ($urandom_range(0, 3)) begin
					len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 63)
						: $urandom_range(1, 6);
					new_targets.push_back(pkt.size());
					pkt.push_back(8'(len));
					repeat (len)
						pkt.push_back(8'($urandom));
				end
				// end the name with a pointer to an earlier name or label,
				// or with the root label
				if (targets.size() != 0 && $urandom_range(0, 1) == 1) begin
					t = targets[$urandom_range(0, targets.size() - 1)];
					pkt.push_back(LABEL_TYPE_MASK | 8'(t >> 8));
					pkt.push_back(8'(t));
				end else begin
					pkt.push_back(8'h00);
				end
				foreach (new_targets[i])
					targets.push_back(new_targets[i]);
			end
			if ($urandom_range(0, 3) == 0)
				pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
		end
		queue_packet(pkt, $urandom_range(0, 9) != 0);
		repeat ($urandom_range(1, 5)) begin
			pick = $urandom_range(0, 9);
			if (pick < 6 && starts.size() != 0)
				queue_decode(POS_W'(starts[$urandom_range(0, starts.size() - 1)]));
			else if (pick < 9)
				queue_decode(POS_W'($urandom_range(0, pkt.size() + 1)));
			else
				queue_decode(POS_W'($urandom));
		end
	endfunction

	// Hold until no item is waiting, offered or owed a result.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || push || due_results.size() != 0);
	endtask

	// Idle, then let a trailing load drain through the block.
	task automatic settle();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_jump_limit(input logic [JUMP_W-1:0] value);
		settle();
		max_jumps_we   <= 1'b1;
		max_jumps_data <= value;
		@(posedge clk);
		max_jumps_we   <= 1'b0;
	endtask

	// Track the register the same edge the block takes it.
	always @(posedge clk) begin
		if (arst_n && max_jumps_we)
			jump_limit <= max_jumps_data;
	end

	// Driver: offer items from the pending queue, with a drawn gap after each
	// accepted item. Hold the offered item until the block takes it.
	always @(posedge clk) begin
		bit accepted;
		accepted = push && !full;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (accepted) begin
				apply_item(offered_item);
				send_wait = draw_wait(send_idle_max);
			end
			if (!push || accepted) begin
				if (send_wait != 0) begin
					send_wait--;
					push <= 1'b0;
				end else if (pending_items.size() != 0) begin
					offered_item = pending_items.pop_front();
					push           <= 1'b1;
					command        <= offered_item.kind;
					data_byte      <= offered_item.data_byte;
					packet_start   <= offered_item.packet_start;
					start_position <= offered_item.start_position;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Monitor: take results with a drawn stall after each one, compare each
	// against the oldest expectation, and serve long hold-off requests.
	always @(posedge clk) begin
		bit   taken;
		res_t want;
		taken = pop && !empty;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (taken) begin
				if (due_results.size() == 0) begin
					$error("result with no decode outstanding");
					fail_count++;
				end else begin
					want = due_results.pop_front();
					check_field("is_final", want.is_final, is_final);
					check_field("label_offset", want.label_offset, label_offset);
					check_field("label_length", want.label_length, label_length);
					check_field("status", want.status, status);
					check_field("next_position", want.next_position, next_position);
					check_field("last_result", want.last_result, last_result);
				end
				recv_wait = draw_wait(recv_idle_max);
			end
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				recv_wait    = LONG_HOLD;
			end
			if (recv_wait != 0) begin
				recv_wait--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		byte_q_t     big;
		int unsigned phase_base;
		// assert reset with an edge so the block clears before the first clock
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed packet at the reset jump limit of 16:
		//   0  "www.x"            plain name
		//   7  "mn" + ptr to 4    pointer into the middle of a name
		//   12 0x40               reserved label type
		//   13 ptr 0x00ff         target past the packet
		//   15 ptr to itself      pointer loop, too many jumps
		//   17 length 63          label runs past the packet
		//   18 0xc0               pointer byte as the last byte
		queue_packet('{8'h03, 8'h77, 8'h77, 8'h77, 8'h01, 8'h78, 8'h00, 8'h02,
			8'h6d, 8'h6e, 8'hc0, 8'h04, 8'h40, 8'hc0, 8'hff, 8'hc0, 8'h0f,
			8'h3f, 8'hc0}, 1'b1);
		queue_decode(POS_W'(0));
		queue_decode(POS_W'(7));
		queue_decode(POS_W'(12));
		queue_decode(POS_W'(13));
		queue_decode(POS_W'(15));
		queue_decode(POS_W'(17));
		queue_decode(POS_W'(18));
		queue_decode({POS_W{1'b1}});

		// Label "a" with a pointer back to it: at 63 jumps the walk hits the
		// label cap from offset 0 and the jump limit from offset 2. Stall the
		// results for a long stretch while the sender keeps offering, so both
		// queues fill and the input backs up.
		set_jump_limit(JUMP_W'(63));
		send_idle_max = 0;
		queue_packet('{8'h01, 8'h61, 8'hc0, 8'h00}, 1'b1);
		hold_requests++;
		queue_decode(POS_W'(0));
		queue_decode(POS_W'(2));
		queue_decode(POS_W'(0));
		queue_decode(POS_W'(2));
		queue_packet('{8'h01, 8'h61, 8'hc0, 8'h00}, 1'b1);
		queue_decode(POS_W'(3));

		// Jump limit 0 rejects every pointer.
		set_jump_limit('0);
		send_idle_max = IDLE_MAX;
		queue_decode(POS_W'(0));
		queue_decode(POS_W'(2));
		queue_decode(POS_W'(3));

		// Full buffer plus two dropped bytes, jump limit 1. Names near both
		// ends of the buffer, pointers at and past the last offset, a 63-byte
		// label and a two-pointer chain.
		set_jump_limit(JUMP_W'(1));
		repeat (PACKET_BYTES + 2)
			big.push_back(8'($urandom));
		big[0] = 8'h3f;
		big[64] = 8'hc7;
		big[65] = 8'hc0;
		big[66] = 8'hff;
		big[67] = 8'hff;
		big[68] = 8'hc7;
		big[69] = 8'hff;
		big[70] = 8'hc8;
		big[71] = 8'h00;
		big[72] = 8'h3f;
		big[136] = 8'h00;
		big[138] = 8'hc0;
		big[139] = 8'h44;
		big[1984] = 8'h3e;
		big[PACKET_BYTES - 1] = 8'h00;
		queue_packet(big, 1'b1);
		queue_decode(POS_W'(0));
		queue_decode(POS_W'(66));
		queue_decode(POS_W'(68));
		queue_decode(POS_W'(70));
		queue_decode(POS_W'(72));
		queue_decode(POS_W'(138));
		queue_decode(POS_W'(1984));
		queue_decode(POS_W'(PACKET_BYTES - 1));
		queue_decode(POS_W'(PACKET_BYTES));

		// Random phases, each at its own jump limit and idle mix.
		for (int k = 0; k < RANDOM_PHASES; k++) begin
			case (k)
				0: set_jump_limit(JUMP_W'($urandom_range(2, 62)));
				1: set_jump_limit(JUMP_W'(63));
				2: set_jump_limit('0);
				3: set_jump_limit(JUMP_W'($urandom_range(1, 8)));
				default: set_jump_limit(MAX_JUMPS_RST);
			endcase
			send_idle_max = (k == 1 || k == 3) ? 0 : IDLE_MAX;
			recv_idle_max = (k == 2 || k == 3) ? 0 : IDLE_MAX;
			phase_base = queued_count;
			while (queued_count - phase_base < RANDOM_ITEMS / RANDOM_PHASES) begin
				queue_random_packet();
				// in this phase hold the sender until every result is back
				if (k == 2)
					wait_idle();
			end
		end

		settle();
		if (fail_count == 0 && due_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
